### src/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the bitmap set store: command codes,
// controller states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned BitSelW   = 5;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned ElemIdxW  = 10;
  localparam int unsigned SetSizeW  = 11;
  localparam logic [SetSizeW-1:0] SetSizeRst = 11'd1024;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_CHECK  = 3'd2,
    CMD_TOGGLE = 3'd3,
    CMD_FILL   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_SWEEP
  } state_e;

endpackage

`default_nettype wire

### src/bitmap_set_store.sv
// ----------------------------------------------------------------------------
// bitmap_set_store
// Set of small integers kept as a bitmap in a word-wide synchronous RAM.
// Single-element commands do one read-modify-write; fill and clear sweep
// every word.
// ----------------------------------------------------------------------------
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+----------------------
//  command   | command_i, element_index_i                 | start & !busy
//  result    | present_o, out_of_range_o                  | done_o, one cycle
//  set_size  | set_size_i                                 | set_size_we_i
//
//  Add, remove, check, toggle and unused codes do one read-modify-write:
//  the word is read on the accept edge and, for in-range add, remove and
//  toggle, written back in the following cycle. Fill and clear sweep every
//  RAM word, one per cycle; after reset a clear sweep runs with busy high.
//  The result register frees the controller, so a new transaction is taken in
//  the cycle that done_o is shown; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_set_store #(
  parameter int unsigned MaxElements = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bss_pkg::CmdW-1:0]      command_i,
  input  wire logic [bss_pkg::ElemIdxW-1:0]  element_index_i,
  output logic                               done_o,
  output logic                               present_o,
  output logic                               out_of_range_o,
  input  wire logic                          set_size_we_i,
  input  wire logic [bss_pkg::SetSizeW-1:0]  set_size_i
);
  import bss_pkg::*;

  localparam int unsigned WordCount = (MaxElements + WordBits - 1) / WordBits;
  localparam int unsigned AddrW     = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned CmpW      = AddrW + BitSelW + 1;
  localparam int unsigned LimW      = (CmpW > SetSizeW) ? CmpW : SetSizeW;
  localparam logic [LimW-1:0]  MaxLim   = LimW'(MaxElements);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WordCount - 1);
  localparam logic [LimW-1:0]  WordSpan = LimW'(WordBits);

  logic [WordBits-1:0] mem [WordCount];

  state_e                state_q, state_d;
  logic [SetSizeW-1:0]   set_size_q;
  logic [CmdW-1:0]       cmd_q, cmd_d;
  logic [BitSelW-1:0]    bit_q, bit_d;
  logic [AddrW-1:0]      addr_q, addr_d;
  logic                  oor_q, oor_d;
  logic [AddrW-1:0]      cnt_q, cnt_d;
  logic [LimW-1:0]       sweep_lim_q, sweep_lim_d;
  logic                  report_q, report_d;
  logic                  done_q, done_d;
  logic                  present_q, present_d;
  logic                  res_oor_q, res_oor_d;

  logic [WordBits-1:0]   rd_data_q;
  logic [AddrW-1:0]      rd_addr;
  logic [AddrW+BitSelW-1:0] word_wide;
  logic [LimW-1:0]       eff_lim;
  logic [LimW-1:0]       idx_ext;
  logic                  single_cmd;
  logic                  accept;

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [WordBits-1:0]   mem_wdata;
  logic [WordBits-1:0]   bit_mask;
  logic [WordBits-1:0]   fill_word;
  logic [LimW-1:0]       base;
  logic [LimW-1:0]       diff;

  assign accept     = start && !busy;
  assign busy       = (state_q != ST_IDLE);
  assign eff_lim    = (LimW'(set_size_q) > MaxLim) ? MaxLim : LimW'(set_size_q);
  assign idx_ext    = LimW'(element_index_i);
  assign single_cmd = (command_i <= CMD_TOGGLE);
  assign word_wide  = (AddrW + BitSelW)'(element_index_i[ElemIdxW-1:BitSelW]);
  assign rd_addr    = word_wide[AddrW-1:0];
  assign bit_mask   = WordBits'(1) << bit_q;

  // Fill pattern of the word under the sweep counter.
  assign base = LimW'({cnt_q, {BitSelW{1'b0}}});
  assign diff = sweep_lim_q - base;
  always_comb begin
    if (base + WordSpan <= sweep_lim_q) begin
      fill_word = '1;
    end else if (base >= sweep_lim_q) begin
      fill_word = '0;
    end else begin
      fill_word = (WordBits'(1) << diff[BitSelW-1:0]) - WordBits'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    bit_d       = bit_q;
    addr_d      = addr_q;
    oor_d       = oor_q;
    cnt_d       = cnt_q;
    sweep_lim_d = sweep_lim_q;
    report_d    = report_q;
    done_d      = 1'b0;
    present_d   = 1'b0;
    res_oor_d   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = rd_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d  = command_i;
          bit_d  = element_index_i[BitSelW-1:0];
          addr_d = rd_addr;
          oor_d  = single_cmd && (idx_ext >= eff_lim);
          if (command_i == CMD_FILL || command_i == CMD_CLEAR) begin
            state_d     = ST_SWEEP;
            cnt_d       = '0;
            report_d    = 1'b1;
            sweep_lim_d = (command_i == CMD_FILL) ? eff_lim : '0;
          end else begin
            state_d = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        // Modify the word read on the accept edge and write it back.
        state_d   = ST_IDLE;
        done_d    = 1'b1;
        res_oor_d = oor_q;
        if (!oor_q) begin
          priority case (cmd_q)
            CMD_ADD: begin
              mem_we    = 1'b1;
              mem_wdata = rd_data_q | bit_mask;
            end
            CMD_REMOVE: begin
              mem_we    = 1'b1;
              mem_wdata = rd_data_q & ~bit_mask;
            end
            CMD_TOGGLE: begin
              mem_we    = 1'b1;
              mem_wdata = rd_data_q ^ bit_mask;
            end
            CMD_CHECK: begin
              present_d = rd_data_q[bit_q];
            end
            default: begin
              mem_we = 1'b0;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = fill_word;
        cnt_d     = cnt_q + AddrW'(1);
        if (cnt_q == LastAddr) begin
          state_d = ST_IDLE;
          done_d  = report_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      set_size_q  <= SetSizeRst;
      cnt_q       <= '0;
      sweep_lim_q <= '0;
      report_q    <= 1'b0;
      done_q      <= 1'b0;
      cmd_q       <= '0;
      oor_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sweep_lim_q <= sweep_lim_d;
      report_q    <= report_d;
      done_q      <= done_d;
      cmd_q       <= cmd_d;
      oor_q       <= oor_d;
      if (set_size_we_i) begin
        set_size_q <= set_size_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q     <= bit_d;
    addr_q    <= addr_d;
    present_q <= present_d;
    res_oor_q <= res_oor_d;
  end

  // Word RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign done_o         = done_q;
  assign present_o      = done_q && present_q;
  assign out_of_range_o = done_q && res_oor_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_rmw_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) |=> done_o)
    else $error("read-modify-write gave no result");

  a_present_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(present_o && out_of_range_o))
    else $error("result both present and out of range");

  a_no_oor_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW && oor_q) |-> !mem_we)
    else $error("out-of-range command wrote the store");

  a_sweep_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && cnt_q != LastAddr) |=> !done_o)
    else $error("result shown in the middle of a sweep");

endmodule

`default_nettype wire

### tb/bitmap_set_store_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_set_store_test
// Self-checking bench for the bitmap set store. A shadow bitmap predicts the
// present and out-of-range flags of every accepted command; results are
// matched in order. A directed block covers the edges, then randomized
// phases run under a range of set sizes, two in three with random sender gaps.
// ----------------------------------------------------------------------------

module bitmap_set_store_test;
  import bss_pkg::*;

  localparam int unsigned MaxElems   = 1024;
  localparam int unsigned WordCount  = MaxElems / WordBits;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned PhaseCount = 9;
  localparam logic [CmdW-1:0] CmdSpare6 = 3'd6;
  localparam logic [CmdW-1:0] CmdSpare7 = 3'd7;

  typedef struct {
    logic [CmdW-1:0]     cmd;
    logic [ElemIdxW-1:0] idx;
    logic                present;
    logic                oor;
  } membership_t;

  // Shadow copy of the bitmap and the set size register.
  class membership_tracker;
    logic [WordBits-1:0] words [WordCount];
    logic [SetSizeW-1:0] size_reg;
    membership_t         expected_flags [$];
    int unsigned         errors;

    function new();
      foreach (words[w]) words[w] = '0;
      size_reg = SetSizeRst;
      errors   = 0;
    endfunction

    function int unsigned limit();
      return (size_reg > MaxElems) ? MaxElems : int'(size_reg);
    endfunction

    function int unsigned pending();
      return expected_flags.size();
    endfunction

    function void write_set_size(logic [SetSizeW-1:0] value);
      size_reg = value;
    endfunction

    function void fill_words(int unsigned lim);
      int unsigned base;
      for (int unsigned w = 0; w < WordCount; w++) begin
        base = w * WordBits;
        if (base + WordBits <= lim) begin
          words[w] = '1;
        end else if (base >= lim) begin
          words[w] = '0;
        end else begin
          words[w] = (32'h1 << (lim - base)) - 32'h1;
        end
      end
    endfunction

    function void note_command(logic [CmdW-1:0] cmd, logic [ElemIdxW-1:0] idx);
      membership_t         exp_item;
      int unsigned         lim;
      int unsigned         w;
      logic [WordBits-1:0] mask;
      lim      = limit();
      exp_item = '{cmd: cmd, idx: idx, present: 1'b0, oor: 1'b0};
      w        = idx / WordBits;
      mask     = 32'h1 << (idx % WordBits);
      case (cmd)
        CMD_ADD, CMD_REMOVE, CMD_CHECK, CMD_TOGGLE: begin
          if (idx >= lim) begin
            exp_item.oor = 1'b1;
          end else begin
            case (cmd)
              CMD_ADD:    words[w] = words[w] | mask;
              CMD_REMOVE: words[w] = words[w] & ~mask;
              CMD_CHECK:  exp_item.present = |(words[w] & mask);
              default:    words[w] = words[w] ^ mask;
            endcase
          end
        end
        CMD_FILL:  fill_words(lim);
        CMD_CLEAR: fill_words(0);
        default: ;
      endcase
      expected_flags.push_back(exp_item);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    function void check_result(logic present, logic oor);
      membership_t exp_item;
      if (expected_flags.size() == 0) begin
        report($sformatf("result present=%b oor=%b with no command pending",
                         present, oor));
        return;
      end
      exp_item = expected_flags.pop_front();
      if (present !== exp_item.present || oor !== exp_item.oor) begin
        report($sformatf("cmd=%0d idx=%0d: expected present=%b oor=%b, got present=%b oor=%b",
                         exp_item.cmd, exp_item.idx, exp_item.present, exp_item.oor,
                         present, oor));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CmdW-1:0]     command_i = '0;
  logic [ElemIdxW-1:0] element_index_i = '0;
  logic                done_o;
  logic                present_o;
  logic                out_of_range_o;
  logic                set_size_we_i = 1'b0;
  logic [SetSizeW-1:0] set_size_i = SetSizeRst;

  membership_tracker tracker = new();

  bitmap_set_store #(
    .MaxElements(MaxElems)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .element_index_i(element_index_i),
    .done_o         (done_o),
    .present_o      (present_o),
    .out_of_range_o (out_of_range_o),
    .set_size_we_i  (set_size_we_i),
    .set_size_i     (set_size_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(present_o, out_of_range_o);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_command(logic [CmdW-1:0] cmd, logic [ElemIdxW-1:0] idx);
    start           <= 1'b1;
    command_i       <= cmd;
    element_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tracker.note_command(cmd, idx);
    @(negedge clk_i);
  endtask

  // Drop start and put noise on the command fields for an idle gap.
  task automatic idle_gap(int unsigned cycles);
    if (cycles > 0) begin
      start           <= 1'b0;
      command_i       <= CmdW'($urandom);
      element_index_i <= ElemIdxW'($urandom);
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending() != 0 || busy) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_set_size(logic [SetSizeW-1:0] value);
    set_size_we_i <= 1'b1;
    set_size_i    <= value;
    @(negedge clk_i);
    set_size_we_i <= 1'b0;
    tracker.write_set_size(value);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CmdW-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_FILL;
    if (r < 6) return CMD_CLEAR;
    if (r < 9) return ($urandom_range(0, 1) != 0) ? CmdSpare6 : CmdSpare7;
    return CmdW'($urandom_range(CMD_ADD, CMD_TOGGLE));
  endfunction

  // Often a hot window so that checks hit set bits, also the boundary.
  function automatic logic [ElemIdxW-1:0] pick_index(int unsigned lim, int unsigned hot_base);
    int unsigned r;
    int          idx;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      idx = hot_base + $urandom_range(0, 63);
    end else if (r < 65 && lim > 0) begin
      idx = $urandom_range(0, lim - 1);
    end else if (r < 85) begin
      idx = $urandom_range(0, 1023);
    end else begin
      idx = int'(lim) + int'($urandom_range(0, 3)) - 2;
    end
    if (idx < 0) idx = 0;
    if (idx > 1023) idx = 1023;
    return ElemIdxW'(idx);
  endfunction

  function automatic logic [SetSizeW-1:0] phase_size(int unsigned phase);
    case (phase)
      0: return 11'd1024;
      1: return 11'd0;
      2: return 11'd2047;
      3: return 11'd1;
      4: return 11'd32;
      5: return SetSizeW'($urandom_range(2, 1023));
      6: return 11'd33;
      7: return SetSizeW'($urandom_range(0, 2047));
      default: return 11'd1023;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned lim;
    int unsigned hot_base;
    bit          gaps_on;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // directed: full-size edges, spare codes, fill and clear
    send_command(CMD_ADD, 10'd0);
    send_command(CMD_ADD, 10'd1023);
    send_command(CMD_CHECK, 10'd0);
    send_command(CMD_CHECK, 10'd1023);
    send_command(CMD_CHECK, 10'd512);
    send_command(CMD_TOGGLE, 10'd31);
    send_command(CMD_TOGGLE, 10'd32);
    send_command(CMD_CHECK, 10'd31);
    send_command(CMD_REMOVE, 10'd0);
    send_command(CMD_CHECK, 10'd0);
    send_command(CmdSpare6, 10'd1023);
    send_command(CmdSpare7, 10'd0);
    send_command(CMD_FILL, 10'd5);
    send_command(CMD_CHECK, 10'd700);
    send_command(CMD_CLEAR, 10'd1023);
    send_command(CMD_CHECK, 10'd1023);

    // zero size rejects everything and fill leaves the store empty
    wait_idle();
    write_set_size(11'd0);
    send_command(CMD_ADD, 10'd0);
    send_command(CMD_FILL, 10'd0);
    send_command(CMD_CHECK, 10'd0);

    // oversize saturates to the full range
    wait_idle();
    write_set_size(11'd2047);
    send_command(CMD_ADD, 10'd1000);
    send_command(CMD_CHECK, 10'd1023);

    // lowered size hides stored bits, raising it shows them again
    wait_idle();
    write_set_size(11'd500);
    send_command(CMD_CHECK, 10'd1000);
    send_command(CMD_TOGGLE, 10'd499);
    wait_idle();
    write_set_size(11'd1024);
    send_command(CMD_CHECK, 10'd1000);

    // partial last word on fill
    wait_idle();
    write_set_size(11'd33);
    send_command(CMD_FILL, 10'd0);
    wait_idle();
    write_set_size(11'd1024);
    send_command(CMD_CHECK, 10'd32);
    send_command(CMD_CHECK, 10'd33);

    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      write_set_size(phase_size(phase));
      lim      = tracker.limit();
      hot_base = (lim > 64) ? $urandom_range(0, lim - 64) : 0;
      gaps_on  = (phase % 3) != 0;
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if (gaps_on) idle_gap(pick_gap());
        send_command(pick_command(), pick_index(lim, hot_base));
      end
    end

    start <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // End the run if neither side moves a transaction for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
src/bss_pkg.sv
src/bitmap_set_store.sv
tb/bitmap_set_store_test.sv
